// ----- sv/tsal_pkg.sv -----
// package for the touch sample averager: codes, control word and microprogram
package tsal_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SHIFT    = 3;
  localparam int unsigned AVG_W    = WORD_W - SHIFT;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned SUM_W    = AVG_W + CNT_W;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned NCH      = 4;
  localparam int unsigned CH_W     = $clog2(NCH);
  localparam int unsigned BIT_W    = $clog2(AVG_W);
  localparam int unsigned PC_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0]  MAX_SAMPLES_RST   = 8'd200;
  localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 1'b1;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [3:0] {
    MODE_IDLE         = 4'b0001,
    MODE_CAPTURE      = 4'b0010,
    MODE_WAIT_RELEASE = 4'b0100,
    MODE_LOCKOUT      = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_NO_EMIT,
    C_BIT_MORE,
    C_CH_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic            in_rdy;
    logic            eval;
    logic            div_load;
    logic            div_step;
    logic            div_store;
    logic            out_load;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] PC_EVAL  = 3'd1;
  localparam logic [PC_W-1:0] PC_LOAD  = 3'd2;
  localparam logic [PC_W-1:0] PC_STEP  = 3'd3;
  localparam logic [PC_W-1:0] PC_STORE = 3'd4;
  localparam logic [PC_W-1:0] PC_OUT   = 3'd5;
  localparam logic [PC_W-1:0] PC_BACK  = 3'd6;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{in_rdy: 1'b0, eval: 1'b0, div_load: 1'b0, div_step: 1'b0,
          div_store: 1'b0, out_load: 1'b0, cond: C_ALWAYS, tgt: PC_IDLE};
    case (pc)
      PC_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_NO_ACCEPT;
        w.tgt    = PC_IDLE;
      end
      PC_EVAL: begin
        w.eval = 1'b1;
        w.cond = C_NO_EMIT;
        w.tgt  = PC_IDLE;
      end
      PC_LOAD: begin
        w.div_load = 1'b1;
        w.cond     = C_NEXT;
      end
      PC_STEP: begin
        w.div_step = 1'b1;
        w.cond     = C_BIT_MORE;
        w.tgt      = PC_STEP;
      end
      PC_STORE: begin
        w.div_store = 1'b1;
        w.cond      = C_CH_MORE;
        w.tgt       = PC_LOAD;
      end
      PC_OUT: begin
        w.out_load = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.tgt      = PC_OUT;
      end
      PC_BACK: begin
        w.cond = C_ALWAYS;
        w.tgt  = PC_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.tgt  = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/touch_sample_averager_lockout.sv -----
// Touch sample averager with release lockout, microcoded top level.
// A tick, or a set that ends no capture, is accepted and evaluated, then the block returns to
// idle. A set that ends a capture is accepted and evaluated, then the four averages come from
// one shared restoring divider, 13 iterations per channel plus a load and a store step, then
// an output load and a return step follow before the next beat is taken. The result then sits
// in an output register while the next beat is accepted; a second result waits only if the
// first has not yet been taken. Configuration writes are always ready and should be issued
// only while the block is idle.
module touch_sample_averager_lockout
  import tsal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic                 in_pen_down,
  input  logic [WORD_W-1:0]    in_x_word,
  input  logic [WORD_W-1:0]    in_y_word,
  input  logic [WORD_W-1:0]    in_z1_word,
  input  logic [WORD_W-1:0]    in_z2_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [AVG_W-1:0]     out_avg_x,
  output logic [AVG_W-1:0]     out_avg_y,
  output logic [AVG_W-1:0]     out_avg_z1,
  output logic [AVG_W-1:0]     out_avg_z2,
  output logic [CNT_W-1:0]     out_sample_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic [PC_W-1:0]   pc_r, pc_nxt;
  ctl_t              ctl;
  logic              jmp;
  logic              in_acc;

  logic [CNT_W-1:0]  max_samples_r;
  logic [TICK_W-1:0] lockout_ticks_r;

  logic              req_r;
  logic              pen_r;
  logic [AVG_W-1:0]  w_r [NCH];

  mode_t             mode_r, mode_nxt;
  logic [SUM_W-1:0]  sum_r [NCH];
  logic [SUM_W-1:0]  sum_nxt [NCH];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TICK_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0]  limit;
  logic              emit;
  logic              accum;

  logic [CH_W-1:0]   ch_r;
  logic [BIT_W-1:0]  bit_r;
  logic [CNT_W-1:0]  rem_r;
  logic [AVG_W-1:0]  dvd_r;
  logic [AVG_W-1:0]  quo_r;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [SUM_W-1:0]  sum_sel;
  logic [AVG_W-1:0]  avg_r [NCH];
  logic              out_busy;

  assign ctl       = ucode(pc_r);
  assign in_stall  = ~ctl.in_rdy;
  assign in_acc    = in_valid & ctl.in_rdy;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid & out_stall;

  // item evaluation
  always_comb begin
    mode_nxt = mode_r;
    left_nxt = left_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    accum    = 1'b0;
    limit    = (max_samples_r == '0) ? CNT_W'(1) : max_samples_r;
    for (int k = 0; k < NCH; k++) sum_nxt[k] = sum_r[k];
    if (req_r == REQ_TICK) begin
      if (mode_r == MODE_LOCKOUT) begin
        if (left_r <= TICK_W'(1)) begin
          left_nxt = '0;
          mode_nxt = MODE_IDLE;
        end else begin
          left_nxt = left_r - TICK_W'(1);
        end
      end
    end else begin
      case (mode_r)
        MODE_WAIT_RELEASE: begin
          if (!pen_r) begin
            mode_nxt = (lockout_ticks_r == '0) ? MODE_IDLE : MODE_LOCKOUT;
            left_nxt = lockout_ticks_r;
          end
        end
        MODE_IDLE: begin
          if (pen_r) begin
            accum = 1'b1;
            for (int k = 0; k < NCH; k++) sum_nxt[k] = SUM_W'(w_r[k]);
            cnt_nxt = CNT_W'(1);
          end
        end
        MODE_CAPTURE: begin
          accum = 1'b1;
          for (int k = 0; k < NCH; k++) sum_nxt[k] = sum_r[k] + SUM_W'(w_r[k]);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        default: ;
      endcase
      if (accum) begin
        mode_nxt = MODE_CAPTURE;
        if (!pen_r || cnt_nxt >= limit) begin
          emit = 1'b1;
          if (pen_r) begin
            mode_nxt = MODE_WAIT_RELEASE;
          end else begin
            mode_nxt = (lockout_ticks_r == '0) ? MODE_IDLE : MODE_LOCKOUT;
            left_nxt = lockout_ticks_r;
          end
        end
      end
    end
  end

  // sequencer
  always_comb begin
    case (ctl.cond)
      C_NEXT:      jmp = 1'b0;
      C_ALWAYS:    jmp = 1'b1;
      C_NO_ACCEPT: jmp = ~in_acc;
      C_NO_EMIT:   jmp = ~emit;
      C_BIT_MORE:  jmp = (bit_r != '0);
      C_CH_MORE:   jmp = (ch_r != CH_W'(NCH - 1));
      C_OUT_BUSY:  jmp = out_busy;
      default:     jmp = 1'b1;
    endcase
    pc_nxt = jmp ? ctl.tgt : pc_r + PC_W'(1);
  end

  // divider step
  assign sum_sel = sum_r[ch_r];
  assign trial   = {rem_r, dvd_r[AVG_W-1]};
  assign qbit    = (trial >= {1'b0, cnt_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r            <= PC_IDLE;
      mode_r          <= MODE_IDLE;
      cnt_r           <= '0;
      left_r          <= '0;
      out_valid       <= 1'b0;
      max_samples_r   <= MAX_SAMPLES_RST;
      lockout_ticks_r <= LOCKOUT_TICKS_RST;
      for (int k = 0; k < NCH; k++) sum_r[k] <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_SAMPLES:   max_samples_r   <= cfg_data[CNT_W-1:0];
          CFG_LOCKOUT_TICKS: lockout_ticks_r <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (ctl.eval) begin
        mode_r <= mode_nxt;
        cnt_r  <= cnt_nxt;
        left_r <= left_nxt;
        for (int k = 0; k < NCH; k++) sum_r[k] <= sum_nxt[k];
      end
      if (ctl.out_load && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_req_type;
      pen_r  <= in_pen_down;
      w_r[0] <= in_x_word[WORD_W-1:SHIFT];
      w_r[1] <= in_y_word[WORD_W-1:SHIFT];
      w_r[2] <= in_z1_word[WORD_W-1:SHIFT];
      w_r[3] <= in_z2_word[WORD_W-1:SHIFT];
    end
    if (ctl.eval) ch_r <= '0;
    if (ctl.div_load) begin
      rem_r <= sum_sel[SUM_W-1:AVG_W];
      dvd_r <= sum_sel[AVG_W-1:0];
      bit_r <= BIT_W'(AVG_W - 1);
    end
    if (ctl.div_step) begin
      rem_r <= qbit ? CNT_W'(trial - {1'b0, cnt_r}) : trial[CNT_W-1:0];
      dvd_r <= {dvd_r[AVG_W-2:0], 1'b0};
      quo_r <= {quo_r[AVG_W-2:0], qbit};
      bit_r <= bit_r - BIT_W'(1);
    end
    if (ctl.div_store) begin
      avg_r[ch_r] <= quo_r;
      ch_r        <= ch_r + CH_W'(1);
    end
    if (ctl.out_load && !out_busy) begin
      out_avg_x        <= avg_r[0];
      out_avg_y        <= avg_r[1];
      out_avg_z1       <= avg_r[2];
      out_avg_z2       <= avg_r[3];
      out_sample_count <= cnt_r;
    end
  end

endmodule
